// ----- hdl/hds_pkg.sv -----
// Shared types and constants for the heartbeat deadline supervisor.
package hds_pkg;

  localparam int unsigned NumModules = 4;
  localparam int unsigned ModW       = 2;
  localparam int unsigned CntW       = 32;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned CfgIdxW    = 3;

  localparam logic [CfgIdxW-1:0] CfgIdxMask = 3'd4;

  typedef enum logic [1:0] {
    OpHeartbeat = 2'd0,
    OpCheck     = 2'd1,
    OpRefresh   = 2'd2
  } opcode_e;

  typedef struct packed {
    logic [NumModules-1:0][TimeW-1:0] deadline;
    logic [NumModules-1:0]            required;
  } cfg_t;

  typedef struct packed {
    logic            hit;
    logic [ModW-1:0] idx;
  } check_t;

endpackage

// ----- hdl/hds_cfg_regs.sv -----
// Configuration register file: per-module deadlines and required mask.
module hds_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [hds_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hds_pkg::TimeW-1:0]    cfg_data_i,
  output hds_pkg::cfg_t                cfg_o
);
  import hds_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      if (cfg_index_i < CfgIdxMask) begin
        cfg_d.deadline[cfg_index_i[ModW-1:0]] = cfg_data_i;
      end else if (cfg_index_i == CfgIdxMask) begin
        cfg_d.required = cfg_data_i[NumModules-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/hds_deadline_check.sv -----
// Parallel elapsed-time compares and lowest-index miss select.
module hds_deadline_check (
  input  hds_pkg::cfg_t                                    cfg_i,
  input  logic [hds_pkg::NumModules-1:0]                   seen_i,
  input  logic [hds_pkg::NumModules-1:0][hds_pkg::TimeW-1:0] hb_time_i,
  input  logic [hds_pkg::TimeW-1:0]                        now_i,
  output hds_pkg::check_t                                  check_o
);
  import hds_pkg::*;

  logic [NumModules-1:0] miss;
  logic [TimeW-1:0]      elapsed [NumModules];

  always_comb begin
    for (int i = 0; i < NumModules; i++) begin
      elapsed[i] = now_i - hb_time_i[i];
      miss[i] = cfg_i.required[i] && (cfg_i.deadline[i] != '0) &&
                (!seen_i[i] || (elapsed[i] > cfg_i.deadline[i]));
    end
  end

  always_comb begin
    check_o = '0;
    for (int i = NumModules - 1; i >= 0; i--) begin
      if (miss[i]) begin
        check_o.hit = 1'b1;
        check_o.idx = ModW'(i);
      end
    end
  end

endmodule

// ----- hdl/heartbeat_deadline_supervisor_unit.sv -----
// Heartbeat deadline supervisor top level: input stage, state, result register.
//
//  channel   direction  handshake                 payload
//  command   in         start && !busy            opcode_i, module_id_i, now_ms_i
//  result    out        done (one cycle)          check_passed_o .. blocked_total_o
//  config    in         cfg_valid && cfg_ready    cfg_index_i, cfg_data_i
//
// A command is taken every cycle. It is captured in the input register, then
// passes the combinational compare and priority select, and its result is
// registered in the result register, which drives done for the result beat.
// busy stays low.
// Reset clears state, counters, done and configuration to zero; input and result data registers are not reset.
// The result receiver cannot stall; each beat is shown for one cycle.
module heartbeat_deadline_supervisor_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   opcode_i,
  input  logic [hds_pkg::ModW-1:0]     module_id_i,
  input  logic [hds_pkg::TimeW-1:0]    now_ms_i,
  output logic                         done,
  output logic                         check_passed_o,
  output logic                         fault_active_o,
  output logic [hds_pkg::ModW-1:0]     fault_module_o,
  output logic [hds_pkg::CntW-1:0]     fault_module_misses_o,
  output logic [hds_pkg::CntW-1:0]     fault_total_o,
  output logic [hds_pkg::CntW-1:0]     refresh_total_o,
  output logic [hds_pkg::CntW-1:0]     blocked_total_o,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [hds_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hds_pkg::TimeW-1:0]    cfg_data_i
);
  import hds_pkg::*;

  cfg_t   cfg;
  check_t check;

  // input stage
  logic             in_valid_q;
  logic [1:0]       op_q;
  logic [ModW-1:0]  id_q;
  logic [TimeW-1:0] now_q;

  // supervisor state
  logic [NumModules-1:0][TimeW-1:0] hb_time_q, hb_time_d;
  logic [NumModules-1:0]            seen_q, seen_d;
  logic [NumModules-1:0][CntW-1:0]  miss_cnt_q, miss_cnt_d;
  logic [CntW-1:0]                  fault_cnt_q, fault_cnt_d;
  logic                             fault_flag_q, fault_flag_d;
  logic [ModW-1:0]                  last_q, last_d;
  logic [CntW-1:0]                  granted_q, granted_d;
  logic [CntW-1:0]                  blocked_q, blocked_d;
  logic                             passed_d;

  // result register
  logic            done_q;
  logic            res_passed_q;
  logic [CntW-1:0] res_misses_q;

  assign busy = 1'b0;

  hds_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hds_deadline_check u_check (
    .cfg_i     (cfg),
    .seen_i    (seen_q),
    .hb_time_i (hb_time_q),
    .now_i     (now_q),
    .check_o   (check)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      op_q  <= opcode_i;
      id_q  <= module_id_i;
      now_q <= now_ms_i;
    end
  end

  always_comb begin
    hb_time_d    = hb_time_q;
    seen_d       = seen_q;
    miss_cnt_d   = miss_cnt_q;
    fault_cnt_d  = fault_cnt_q;
    fault_flag_d = fault_flag_q;
    last_d       = last_q;
    granted_d    = granted_q;
    blocked_d    = blocked_q;
    passed_d     = 1'b0;
    if (in_valid_q) begin
      case (op_q)
        OpHeartbeat: begin
          hb_time_d[id_q] = now_q;
          seen_d[id_q]    = 1'b1;
        end
        OpCheck, OpRefresh: begin
          fault_flag_d = check.hit;
          passed_d     = !check.hit;
          if (check.hit) begin
            miss_cnt_d[check.idx] = miss_cnt_q[check.idx] + 1'b1;
            fault_cnt_d           = fault_cnt_q + 1'b1;
            last_d                = check.idx;
          end
          if (op_q == OpRefresh) begin
            if (check.hit) begin
              blocked_d = blocked_q + 1'b1;
            end else begin
              granted_d = granted_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_time_q    <= '0;
      seen_q       <= '0;
      miss_cnt_q   <= '0;
      fault_cnt_q  <= '0;
      fault_flag_q <= 1'b0;
      last_q       <= '0;
      granted_q    <= '0;
      blocked_q    <= '0;
      done_q       <= 1'b0;
    end else begin
      hb_time_q    <= hb_time_d;
      seen_q       <= seen_d;
      miss_cnt_q   <= miss_cnt_d;
      fault_cnt_q  <= fault_cnt_d;
      fault_flag_q <= fault_flag_d;
      last_q       <= last_d;
      granted_q    <= granted_d;
      blocked_q    <= blocked_d;
      done_q       <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      res_passed_q <= passed_d;
      res_misses_q <= miss_cnt_d[last_d];
    end
  end

  assign done                  = done_q;
  assign check_passed_o        = res_passed_q;
  assign fault_active_o        = fault_flag_q;
  assign fault_module_o        = last_q;
  assign fault_module_misses_o = res_misses_q;
  assign fault_total_o         = fault_cnt_q;
  assign refresh_total_o       = granted_q;
  assign blocked_total_o       = blocked_q;

`ifndef SYNTH
  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> $past(start, 2))
    else $error("result beat without a command two cycles earlier");

  a_pass_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && check_passed_o) |-> !fault_active_o)
    else $error("passed check reported with active fault");

  a_grant_needs_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (refresh_total_o != $past(refresh_total_o)) |-> (done && check_passed_o))
    else $error("refresh count moved without a passed check");

  a_fault_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fault_total_o != $past(fault_total_o)) |->
      (done && fault_active_o && fault_total_o == $past(fault_total_o) + 1'b1))
    else $error("fault total moved without a detected miss");
`endif

endmodule

// ----- tb/hds_checker.sv -----
// Checker for the heartbeat deadline supervisor: mirrors registers, predicts and compares results.
`timescale 1ns / 100ps

module hds_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  input  logic                         busy,
  input  logic [1:0]                   opcode_i,
  input  logic [hds_pkg::ModW-1:0]     module_id_i,
  input  logic [hds_pkg::TimeW-1:0]    now_ms_i,
  input  logic                         done,
  input  logic                         check_passed_o,
  input  logic                         fault_active_o,
  input  logic [hds_pkg::ModW-1:0]     fault_module_o,
  input  logic [hds_pkg::CntW-1:0]     fault_module_misses_o,
  input  logic [hds_pkg::CntW-1:0]     fault_total_o,
  input  logic [hds_pkg::CntW-1:0]     refresh_total_o,
  input  logic [hds_pkg::CntW-1:0]     blocked_total_o,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [hds_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hds_pkg::TimeW-1:0]    cfg_data_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  outstanding_o,
  output int unsigned                  results_o,
  output int unsigned                  misses_o
);
  import hds_pkg::*;

  typedef struct packed {
    logic            passed;
    logic            active;
    logic [ModW-1:0] culprit;
    logic [CntW-1:0] culprit_misses;
    logic [CntW-1:0] faults;
    logic [CntW-1:0] grants;
    logic [CntW-1:0] blocks;
  } status_t;

  logic [TimeW-1:0]      dl_limit    [NumModules];
  logic [NumModules-1:0] required;
  logic [TimeW-1:0]      beat_ms     [NumModules];
  logic [NumModules-1:0] heard;
  logic [CntW-1:0]       late_tally  [NumModules];
  logic [CntW-1:0]       flt_tally;
  logic                  fault_flag;
  logic [ModW-1:0]       culprit;
  logic [CntW-1:0]       grant_count;
  logic [CntW-1:0]       block_count;

  status_t     status_due [$];
  status_t     want;
  status_t     got;
  int unsigned fail_total;
  int unsigned mismatches;
  int unsigned result_count;

  function automatic status_t supervise_step(input logic [1:0] op, input logic [ModW-1:0] id,
                                             input logic [TimeW-1:0] now);
    status_t          s;
    logic             ok;
    logic [TimeW-1:0] age;
    ok = 1'b0;
    if (op == OpHeartbeat) begin
      beat_ms[id] = now;
      heard[id]   = 1'b1;
    end else if (op == OpCheck || op == OpRefresh) begin
      fault_flag = 1'b0;
      ok = 1'b1;
      for (int i = 0; i < NumModules && ok; i++) begin
        age = now - beat_ms[i];
        if (required[i] && dl_limit[i] != '0 && (!heard[i] || age > dl_limit[i])) begin
          late_tally[i] = late_tally[i] + 1'b1;
          flt_tally     = flt_tally + 1'b1;
          fault_flag    = 1'b1;
          culprit       = ModW'(i);
          ok            = 1'b0;
        end
      end
      if (op == OpRefresh) begin
        if (ok) grant_count = grant_count + 1'b1;
        else block_count = block_count + 1'b1;
      end
    end
    s = {ok, fault_flag, culprit, late_tally[culprit], flt_tally, grant_count, block_count};
    return s;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumModules; i++) begin
        dl_limit[i]   = '0;
        beat_ms[i]    = '0;
        late_tally[i] = '0;
      end
      required     = '0;
      heard        = '0;
      flt_tally    = '0;
      fault_flag   = 1'b0;
      culprit      = '0;
      grant_count  = '0;
      block_count  = '0;
      fail_total   = 0;
      mismatches   = 0;
      result_count = 0;
      status_due.delete();
      fail_count_o  <= 0;
      outstanding_o <= 0;
      results_o     <= 0;
      misses_o      <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index_i < NumModules) dl_limit[cfg_index_i] = cfg_data_i;
        else if (cfg_index_i == CfgIdxMask) required = cfg_data_i[NumModules-1:0];
      end
      if (done) begin
        result_count++;
        got = {check_passed_o, fault_active_o, fault_module_o, fault_module_misses_o,
               fault_total_o, refresh_total_o, blocked_total_o};
        if (status_due.size() == 0) begin
          fail_total++;
          if (mismatches < 10)
            $display("%0t: result beat with nothing expected", $realtime);
          mismatches++;
        end else begin
          want = status_due.pop_front();
          if (got !== want) begin
            fail_total++;
            if (mismatches < 10) begin
              $display("%0t: mismatch exp pass=%0b flt=%0b mod=%0d miss=%0d tot=%0d ref=%0d blk=%0d",
                       $realtime, want.passed, want.active, want.culprit, want.culprit_misses,
                       want.faults, want.grants, want.blocks);
              $display("             got pass=%0b flt=%0b mod=%0d miss=%0d tot=%0d ref=%0d blk=%0d",
                       got.passed, got.active, got.culprit, got.culprit_misses,
                       got.faults, got.grants, got.blocks);
            end
            mismatches++;
          end
        end
      end
      if (start && !busy) status_due.push_back(supervise_step(opcode_i, module_id_i, now_ms_i));
      fail_count_o  <= fail_total;
      outstanding_o <= status_due.size();
      results_o     <= result_count;
      misses_o      <= flt_tally;
    end
  end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the heartbeat deadline supervisor: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;
  import hds_pkg::*;

  localparam logic [1:0] OpReserved = 2'd3;
  localparam int unsigned IdleLimit  = 1000;
  localparam int unsigned PhaseCount = 6;
  localparam int unsigned PhaseItems = 72;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic [1:0]            opcode_i    = '0;
  logic [ModW-1:0]       module_id_i = '0;
  logic [TimeW-1:0]      now_ms_i    = '0;
  logic                  cfg_valid   = 1'b0;
  logic [CfgIdxW-1:0]    cfg_index_i = '0;
  logic [TimeW-1:0]      cfg_data_i  = '0;
  logic                  busy;
  logic                  done;
  logic                  check_passed_o;
  logic                  fault_active_o;
  logic [ModW-1:0]       fault_module_o;
  logic [CntW-1:0]       fault_module_misses_o;
  logic [CntW-1:0]       fault_total_o;
  logic [CntW-1:0]       refresh_total_o;
  logic [CntW-1:0]       blocked_total_o;
  logic                  cfg_ready;
  int unsigned           fail_count_o;
  int unsigned           outstanding_o;
  int unsigned           results_o;
  int unsigned           misses_o;

  bit                    gaps_on = 1'b1;
  int unsigned           cmd_count;
  int unsigned           reg_writes;
  int unsigned           settings;
  int unsigned           idle_cycles;

  heartbeat_deadline_supervisor_unit u_top (.*);
  hds_checker u_checker (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || (cfg_valid && cfg_ready) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_cmd(input logic [1:0] op, input logic [ModW-1:0] id,
                          input logic [TimeW-1:0] now);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    start       <= 1'b1;
    opcode_i    <= op;
    module_id_i <= id;
    now_ms_i    <= now;
    do @(posedge clk_i); while (busy);
    cmd_count++;
  endtask

  // hold the sender off until every result is back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (outstanding_o != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TimeW-1:0] data);
    cfg_valid   <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    reg_writes++;
  endtask

  task automatic program_regs(input logic [NumModules-1:0][TimeW-1:0] dl,
                              input logic [NumModules-1:0] mask, input bit spare);
    for (int i = 0; i < NumModules; i++) write_reg(CfgIdxW'(i), dl[i]);
    write_reg(CfgIdxMask, ($urandom & ~TimeW'({NumModules{1'b1}})) | TimeW'(mask));
    if (spare)
      for (int k = CfgIdxMask + 1; k < (1 << CfgIdxW); k++) write_reg(CfgIdxW'(k), $urandom);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  function automatic logic [TimeW-1:0] pick_deadline();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return TimeW'(1);
      2:       return '1;
      3:       return $urandom;
      default: return $urandom_range(2, 60);
    endcase
  endfunction

  initial begin
    logic [NumModules-1:0][TimeW-1:0] dl;
    logic [TimeW-1:0]                 ms;
    logic [ModW-1:0]                  id;
    int unsigned                      counted;
    int unsigned                      r;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset registers: everything disabled
    send_cmd(OpRefresh, 2'd0, '0);
    send_cmd(OpCheck, 2'd3, '1);
    send_cmd(OpReserved, 2'd3, '1);
    drain();
    program_regs({32'd100, 32'd1, 32'hFFFF_FFFF, 32'd10}, 4'hF, 1'b1);
    send_cmd(OpCheck, 2'd0, '0);                    // never heard from
    for (int i = 0; i < NumModules - 1; i++) send_cmd(OpHeartbeat, ModW'(i), 32'hFFFF_FFFA);
    send_cmd(OpHeartbeat, 2'd3, '1);
    send_cmd(OpRefresh, 2'd0, 32'd4);               // wrapped age, module 2 late
    send_cmd(OpHeartbeat, 2'd2, 32'd4);
    send_cmd(OpRefresh, 2'd1, 32'd4);
    send_cmd(OpCheck, 2'd0, 32'd5);
    send_cmd(OpHeartbeat, 2'd0, 32'd5);
    send_cmd(OpCheck, 2'd2, 32'd6);
    send_cmd(OpReserved, 2'd0, '0);
    drain();
    program_regs({32'd100, 32'd1, 32'hFFFF_FFFF, 32'd10}, 4'b1010, 1'b0);
    send_cmd(OpCheck, 2'd1, 32'd1000);
    send_cmd(OpHeartbeat, 2'd3, 32'd1000);
    send_cmd(OpRefresh, 2'd0, 32'd1100);            // age equals deadline
    send_cmd(OpRefresh, 2'd0, 32'd1101);

    ms = $urandom;
    for (int p = 0; p < PhaseCount; p++) begin
      drain();
      for (int m = 0; m < NumModules; m++) dl[m] = pick_deadline();
      program_regs(dl, (p == 0) ? 4'hF : (p == 1) ? 4'h0 : NumModules'($urandom), p == 2);
      gaps_on = (p != PhaseCount - 1);
      counted = 0;
      while (counted < PhaseItems) begin
        r  = $urandom_range(0, 99);
        id = ModW'($urandom);
        ms = ms + $urandom_range(0, 12);
        if (r < 45) send_cmd(OpHeartbeat, id, ms);
        else if (r < 65) send_cmd(OpCheck, id, ms);
        else if (r < 85) send_cmd(OpRefresh, id, ms);
        else if (r < 90) send_cmd(OpReserved, id, ms);
        else send_cmd(2'($urandom), id, $urandom);
        if (r < 85 || r >= 90) counted++;
      end
    end

    drain();
    repeat (4) @(posedge clk_i);
    $display("Covered %0d commands and %0d register writes over %0d register settings;",
             cmd_count, reg_writes, settings);
    $display("%0d results compared, %0d deadline misses predicted.", results_o, misses_o);
    if (fail_count_o == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
